[rtl/segint_pkg.sv]
// Shared widths, payload types and cell data types for the segment intersection block.
package segint_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DW  = COORD_WIDTH + 1;   // coordinate difference
    localparam int PW  = 2 * DW;            // one cross-product term
    localparam int XW  = PW + 1;            // cross product
    localparam int MW  = XW;                // cross-product magnitude
    localparam int QW  = DW;                // quotient bits, one per cell
    localparam int D2W = MW + 1;            // doubled denominator
    localparam int LOW = MW / 2;            // low slice of the numerator magnitude
    localparam int HIW = MW - LOW;
    localparam int NW  = DW + MW + 2;       // rounded dividend

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_begin_x;
        logic signed [COORD_WIDTH-1:0] first_begin_y;
        logic signed [COORD_WIDTH-1:0] first_end_x;
        logic signed [COORD_WIDTH-1:0] first_end_y;
        logic signed [COORD_WIDTH-1:0] second_begin_x;
        logic signed [COORD_WIDTH-1:0] second_begin_y;
        logic signed [COORD_WIDTH-1:0] second_end_x;
        logic signed [COORD_WIDTH-1:0] second_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                          hit;
        logic                          parallel;
        logic signed [COORD_WIDTH-1:0] cross_x;
        logic signed [COORD_WIDTH-1:0] cross_y;
    } t_seg_out;

    // One division lane: partial remainder, dividend bits still to enter, quotient so far.
    typedef struct packed {
        logic [D2W-1:0] rem;
        logic [QW-1:0]  nsh;
        logic [QW-1:0]  q;
    } t_div_lane;

    // Data that rides along the divider row unchanged.
    typedef struct packed {
        logic                   hit;
        logic                   par;
        logic [COORD_WIDTH-1:0] bx;
        logic [COORD_WIDTH-1:0] by;
        logic                   negx;
        logic                   negy;
        logic [D2W-1:0]         d2;
    } t_div_side;

    typedef struct packed {
        t_div_side side;
        t_div_lane lx;
        t_div_lane ly;
    } t_cell_data;

endpackage

[rtl/segint_div_cell.sv]
// One restoring-division cell: retires one quotient bit for both lanes per request.
module segint_div_cell
    import segint_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_valid,
    output t_cell_data o_data
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    function automatic t_div_lane lane_step(input t_div_lane l, input logic [D2W-1:0] d);
        logic [D2W:0] t;
        t_div_lane    o;
        t = {l.rem, l.nsh[QW-1]};
        o.nsh = {l.nsh[QW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            o.rem = D2W'(t - {1'b0, d});
            o.q   = {l.q[QW-2:0], 1'b1};
        end else begin
            o.rem = t[D2W-1:0];
            o.q   = {l.q[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_data.side = i_data.side;
        n_data.lx   = lane_step(i_data.lx, i_data.side.d2);
        n_data.ly   = lane_step(i_data.ly, i_data.side.d2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/segint_front.sv]
// Front pipeline: differences, cross products, hit test and rounded dividends.
module segint_front
    import segint_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_seg_in    i_data,
    output logic       o_valid,
    output t_cell_data o_data
);

    logic [5:0] r_v;

    // Stage 1
    logic signed [DW-1:0]          r1_rx, r1_ry, r1_sx, r1_sy, r1_ox, r1_oy;
    logic signed [COORD_WIDTH-1:0] r1_bx, r1_by;
    // Stage 2
    logic signed [PW-1:0]          r2_rxsy, r2_rysx, r2_sxoy, r2_syox, r2_rxoy, r2_ryox;
    logic signed [DW-1:0]          r2_rx, r2_ry;
    logic signed [COORD_WIDTH-1:0] r2_bx, r2_by;
    // Stage 3
    logic signed [XW-1:0]          r3_den, r3_na, r3_nb;
    logic signed [DW-1:0]          r3_rx, r3_ry;
    logic signed [COORD_WIDTH-1:0] r3_bx, r3_by;
    // Stage 4
    logic                          r4_hit, r4_par, r4_negx, r4_negy;
    logic [MW-1:0]                 r4_an, r4_ad;
    logic [DW-1:0]                 r4_mx, r4_my;
    logic [COORD_WIDTH-1:0]        r4_bx, r4_by;
    // Stage 5
    logic [DW+LOW-1:0]             r5_plx, r5_ply;
    logic [DW+HIW-1:0]             r5_phx, r5_phy;
    logic                          r5_hit, r5_par, r5_negx, r5_negy;
    logic [MW-1:0]                 r5_ad;
    logic [COORD_WIDTH-1:0]        r5_bx, r5_by;
    // Stage 6
    t_cell_data                    r6_data;

    logic [MW-1:0] n_an, n_ad, n_anb;
    logic          n_ua, n_ub;
    logic [NW-1:0] n_numx, n_numy;

    function automatic logic [MW-1:0] mag(input logic signed [XW-1:0] v);
        return v[XW-1] ? MW'(-v) : MW'(v);
    endfunction

    always_comb begin
        n_an  = mag(r3_na);
        n_anb = mag(r3_nb);
        n_ad  = mag(r3_den);
        // A ratio lies in [0,1] when it is zero, or has the denominator's sign and
        // no larger magnitude.
        n_ua  = (r3_na == '0) || ((r3_na[XW-1] == r3_den[XW-1]) && (n_an <= n_ad));
        n_ub  = (r3_nb == '0) || ((r3_nb[XW-1] == r3_den[XW-1]) && (n_anb <= n_ad));
        n_numx = NW'({NW'(r5_plx) + (NW'(r5_phx) << LOW), 1'b0}) + NW'(r5_ad);
        n_numy = NW'({NW'(r5_ply) + (NW'(r5_phy) << LOW), 1'b0}) + NW'(r5_ad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_rx <= DW'(i_data.first_end_x)  - DW'(i_data.first_begin_x);
            r1_ry <= DW'(i_data.first_end_y)  - DW'(i_data.first_begin_y);
            r1_sx <= DW'(i_data.second_end_x) - DW'(i_data.second_begin_x);
            r1_sy <= DW'(i_data.second_end_y) - DW'(i_data.second_begin_y);
            r1_ox <= DW'(i_data.first_begin_x) - DW'(i_data.second_begin_x);
            r1_oy <= DW'(i_data.first_begin_y) - DW'(i_data.second_begin_y);
            r1_bx <= i_data.first_begin_x;
            r1_by <= i_data.first_begin_y;

            r2_rxsy <= r1_rx * r1_sy;
            r2_rysx <= r1_ry * r1_sx;
            r2_sxoy <= r1_sx * r1_oy;
            r2_syox <= r1_sy * r1_ox;
            r2_rxoy <= r1_rx * r1_oy;
            r2_ryox <= r1_ry * r1_ox;
            r2_rx   <= r1_rx;
            r2_ry   <= r1_ry;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;

            r3_den <= XW'(r2_rxsy) - XW'(r2_rysx);
            r3_na  <= XW'(r2_sxoy) - XW'(r2_syox);
            r3_nb  <= XW'(r2_rxoy) - XW'(r2_ryox);
            r3_rx  <= r2_rx;
            r3_ry  <= r2_ry;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;

            r4_par  <= (r3_den == '0);
            r4_hit  <= (r3_den != '0) && n_ua && n_ub;
            r4_an   <= n_an;
            r4_ad   <= n_ad;
            r4_negx <= r3_rx[DW-1];
            r4_negy <= r3_ry[DW-1];
            r4_mx   <= r3_rx[DW-1] ? DW'(-r3_rx) : DW'(r3_rx);
            r4_my   <= r3_ry[DW-1] ? DW'(-r3_ry) : DW'(r3_ry);
            r4_bx   <= r3_bx;
            r4_by   <= r3_by;

            // The wide product is split in two partial products to keep each multiplier narrow.
            r5_plx  <= r4_mx * r4_an[LOW-1:0];
            r5_ply  <= r4_my * r4_an[LOW-1:0];
            r5_phx  <= r4_mx * r4_an[MW-1:LOW];
            r5_phy  <= r4_my * r4_an[MW-1:LOW];
            r5_hit  <= r4_hit;
            r5_par  <= r4_par;
            r5_negx <= r4_negx;
            r5_negy <= r4_negy;
            r5_ad   <= r4_ad;
            r5_bx   <= r4_bx;
            r5_by   <= r4_by;

            // On a hit the quotient fits QW bits, so the dividend's upper part is below 2|D|.
            r6_data.side.hit  <= r5_hit;
            r6_data.side.par  <= r5_par;
            r6_data.side.bx   <= r5_bx;
            r6_data.side.by   <= r5_by;
            r6_data.side.negx <= r5_negx;
            r6_data.side.negy <= r5_negy;
            r6_data.side.d2   <= {r5_ad, 1'b0};
            r6_data.lx.rem    <= n_numx[QW+D2W-1:QW];
            r6_data.lx.nsh    <= n_numx[QW-1:0];
            r6_data.lx.q      <= '0;
            r6_data.ly.rem    <= n_numy[QW+D2W-1:QW];
            r6_data.ly.nsh    <= n_numy[QW-1:0];
            r6_data.ly.q      <= '0;
        end
    end

    assign o_valid = r_v[5];
    assign o_data  = r6_data;

endmodule

[rtl/segment_intersection.sv]
// Top level of the 2D segment intersection block: front pipeline, divider row, output register.
//
//   channel  | valid    | stall    | payload
//   request  | i_valid  | o_stall  | i_data (t_seg_in)
//   result   | o_valid  | i_stall  | o_data (t_seg_out)
//
// One request enters per cycle while o_stall is low; each result passes through six front
// stages, seventeen divider cells (one quotient bit each) and the output register.
// The whole pipeline advances together; it holds only while a result sits in the
// output register and i_stall is high, and new requests keep entering otherwise.
// Reset clears every valid bit; payload registers are not reset.
module segment_intersection
    import segint_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_seg_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_seg_out o_data
);

    logic       en;
    logic       v_chain [QW+1];
    t_cell_data d_chain [QW+1];
    logic       r_valid;
    t_seg_out   r_data;
    t_cell_data last;
    logic [COORD_WIDTH-1:0] offx, offy;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;

    segint_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (v_chain[0]),
        .o_data  (d_chain[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_cell
        segint_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[g]),
            .i_data  (d_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_data  (d_chain[g+1])
        );
    end

    always_comb begin
        last = d_chain[QW];
        offx = last.side.negx ? COORD_WIDTH'(-last.lx.q) : COORD_WIDTH'(last.lx.q);
        offy = last.side.negy ? COORD_WIDTH'(-last.ly.q) : COORD_WIDTH'(last.ly.q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= v_chain[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data.hit      <= last.side.hit;
            r_data.parallel <= last.side.par;
            r_data.cross_x  <= last.side.hit ? last.side.bx + offx : '0;
            r_data.cross_y  <= last.side.hit ? last.side.by + offy : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[tb/tb_segment_intersection.sv]
// Self-checking testbench for the segment intersection block.
`timescale 1ns / 1ps

module tb_segment_intersection;
    import segint_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int LATENCY = 24;

    typedef logic signed [CW-1:0] t_coord;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_seg_in  i_data = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_seg_out o_data;

    t_seg_out crossing_q[$];
    int       errors = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_recv = 1'b0;

    segment_intersection dut (.*);

    always #5 i_clk = ~i_clk;

    // Exact integer prediction; 64-bit products are wide enough for 16-bit coordinates.
    function automatic t_coord place_coord(longint base, longint dir, longint anum,
                                           longint aden);
        logic [127:0] num;
        logic [127:0] quo;
        longint       mdir;
        longint       off;
        mdir = (dir < 0) ? -dir : dir;
        num  = 128'(mdir) * 128'(anum) * 2 + 128'(aden);
        quo  = num / (128'(aden) * 2);
        off  = longint'(quo[63:0]);
        return t_coord'(base + ((dir < 0) ? -off : off));
    endfunction

    function automatic bit unit_ratio(longint n, longint d);
        longint an;
        longint ad;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        if (n == 0) return 1'b1;
        if ((n < 0) != (d < 0)) return 1'b0;
        return ad >= an;
    endfunction

    function automatic t_seg_out predict_crossing(t_seg_in s);
        t_seg_out r;
        longint b1x, b1y, rx, ry, sx, sy, ox, oy, den, na, nb;
        b1x = longint'(s.first_begin_x);
        b1y = longint'(s.first_begin_y);
        rx  = longint'(s.first_end_x) - b1x;
        ry  = longint'(s.first_end_y) - b1y;
        sx  = longint'(s.second_end_x) - longint'(s.second_begin_x);
        sy  = longint'(s.second_end_y) - longint'(s.second_begin_y);
        ox  = b1x - longint'(s.second_begin_x);
        oy  = b1y - longint'(s.second_begin_y);
        den = rx * sy - ry * sx;
        na  = sx * oy - sy * ox;
        nb  = rx * oy - ry * ox;
        r = '0;
        r.parallel = (den == 0);
        r.hit = (den != 0) && unit_ratio(na, den) && unit_ratio(nb, den);
        if (r.hit) begin
            r.cross_x = place_coord(b1x, rx, (na < 0) ? -na : na, (den < 0) ? -den : den);
            r.cross_y = place_coord(b1y, ry, (na < 0) ? -na : na, (den < 0) ? -den : den);
        end
        return r;
    endfunction

    // Valid stays high between back-to-back requests; idle gaps and drain lower it.
    task automatic send_request(t_seg_in s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= s;
        crossing_q.push_back(predict_crossing(s));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_seg(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
        t_seg_in s;
        s = '{t_coord'(ax), t_coord'(ay), t_coord'(bx), t_coord'(by),
              t_coord'(cx), t_coord'(cy), t_coord'(dx), t_coord'(dy)};
        send_request(s);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (crossing_q.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    function automatic t_coord rand_coord(int span);
        if (span == 0) return t_coord'($urandom);
        return t_coord'($urandom_range(2 * span) - span);
    endfunction

    // Half are crossing pairs: the second segment straddles a point on the first.
    task automatic send_random(int n);
        t_seg_in s;
        int      span;
        for (int i = 0; i < n; i++) begin
            span = ($urandom_range(3) == 0) ? 0 : 256 << $urandom_range(6);
            for (int k = 0; k < 8; k++) s[k*CW +: CW] = rand_coord(span);
            case ($urandom_range(5))
                0, 1, 2: begin
                    s.second_end_x = t_coord'(-s.second_begin_x);
                    s.second_end_y = t_coord'(-s.second_begin_y);
                    s.first_end_x  = t_coord'(-s.first_begin_x);
                    s.first_end_y  = t_coord'(-s.first_begin_y);
                end
                3: s.second_begin_x = s.first_end_x;
                4: begin
                    s.second_end_x = s.second_begin_x + (s.first_end_x - s.first_begin_x);
                    s.second_end_y = s.second_begin_y + (s.first_end_y - s.first_begin_y);
                end
                default: ;
            endcase
            send_request(s);
        end
    endtask

    task automatic test_directed;
        send_seg(0, 0, 256, 256, 0, 256, 256, 0);
        send_seg(0, 0, 256, 0, 0, 256, 256, 256);             // parallel
        send_seg(0, 0, 256, 0, 128, 0, 512, 0);               // collinear overlap
        send_seg(5, 5, 5, 5, 0, 0, 256, 256);                 // zero length
        send_seg(0, 0, 256, 0, 256, -256, 256, 256);          // touch at end
        send_seg(0, 0, 256, 0, 0, 0, 0, 256);                 // touch at start
        send_seg(0, 0, 256, 0, 300, -256, 300, 256);          // miss
        send_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_seg(-32768, 0, 32767, 0, 0, -32768, 1, 32767);
        send_seg(0, 0, 3, 1, 1, 0, 0, 1);                     // fractional crossing, rounded
        send_seg(0, 0, -3, -1, -1, 0, 0, -1);
        send_seg(0, 0, 7, 3, 2, 0, 0, 5);
        send_seg(-1, -1, -1, -1, -1, -1, -1, -1);
        send_seg(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
        send_seg(100, 0, 100, 256, 0, 50, 256, 50);
        drain();
    endtask

    task automatic test_phases;
        int idle_set[4]  = '{0, 51, 0, 35};
        int stall_set[4] = '{0, 0, 51, 35};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_set[p];
            recv_stall_pct = stall_set[p];
            send_random(150);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure;
        hold_recv = 1'b1;
        fork
            begin
                repeat (200) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            send_random(60);
        join
        drain();
        send_random(30);
    endtask

    always @(negedge i_clk) begin
        i_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_seg_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (crossing_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                exp_r = crossing_q.pop_front();
                if (o_data.hit !== exp_r.hit) begin
                    $error("hit: expected %0d, got %0d", exp_r.hit, o_data.hit);
                    errors++;
                end
                if (o_data.parallel !== exp_r.parallel) begin
                    $error("parallel: expected %0d, got %0d", exp_r.parallel, o_data.parallel);
                    errors++;
                end
                if (o_data.cross_x !== exp_r.cross_x) begin
                    $error("cross_x: expected %0d, got %0d", exp_r.cross_x, o_data.cross_x);
                    errors++;
                end
                if (o_data.cross_y !== exp_r.cross_y) begin
                    $error("cross_y: expected %0d, got %0d", exp_r.cross_y, o_data.cross_y);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_phases();
        test_backpressure();
        drain();
        repeat (LATENCY * 2) @(negedge i_clk);
        if (errors == 0 && crossing_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (crossing_q.size() != 0) $error("%0d results never arrived", crossing_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
